>>> rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int EntriesDefault = 16;
  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 5;

  localparam logic [CapW-1:0] CAP_RESET  = 5'd16;
  localparam logic [ValW-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  // One list slot as it moves between cells.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  // Per-cell update command.
  typedef struct packed {
    logic take_head;  // load the new most-recent entry
    logic take_left;  // shift in the neighbor's entry (one step older)
    logic clear;      // drop the entry that would land here
  } cell_ctrl_t;

endpackage

>>> rtl/core/lkvc_cell.sv
// One slot of the recency-ordered list: holds an entry and compares its key.
`timescale 1ns / 1ps
module lkvc_cell import lkvc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  entry_t          head_i,
  input  entry_t          left_i,
  input  logic [KeyW-1:0] lookup_key_i,
  output entry_t          entry_o,
  output logic            match_o
);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] value_q, value_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.take_head) begin
      valid_d = head_i.valid;
      key_d   = head_i.key;
      value_d = head_i.value;
    end else if (ctrl_i.take_left) begin
      valid_d = left_i.valid;
      key_d   = left_i.key;
      value_d = left_i.value;
    end
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};
  assign match_o = valid_q && (key_q == lookup_key_i);

endmodule

>>> rtl/core/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key/value cache.
`timescale 1ns / 1ps
// Entries live in a row of cells kept in recency order: cell 0 is the most
// recent, and the valid cells always form a prefix of the row. In S_IDLE an
// item is accepted, every cell compares the key in parallel and the hit
// position is registered; in S_UPDATE the row shifts (a hit moves to the
// front, a key set on a miss enters at the front and the oldest one falls out
// when the count has reached the capacity) and the result is registered. A
// new item is taken only once S_UPDATE is left; a result that is not taken
// holds the update state until the output frees.
// Capacity 0 acts as 1 and values above ENTRIES act as ENTRIES; lowering it
// never drops entries, but every later insert then evicts.
module lru_key_value_cache_top import lkvc_pkg::*; #(
  parameter int Entries = EntriesDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CapW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic signed [ValW-1:0] read_value_o,
  output logic                   evicted_o
);

  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);

  state_e state_q, state_d;

  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] eff_cap;

  logic            op_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_pos_q;

  logic            out_valid_q;
  logic            out_hit_q, out_hit_d;
  logic [ValW-1:0] out_value_q, out_value_d;
  logic            out_evicted_q, out_evicted_d;

  entry_t     cell_entry [Entries];
  entry_t     cell_left  [Entries];
  cell_ctrl_t cell_ctrl  [Entries];
  logic [Entries-1:0] match;
  logic [IdxW-1:0]    match_pos;

  entry_t head;
  logic   accept, commit, do_move, do_insert, evict;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (int'(cap_q) > Entries) begin
      eff_cap = CntW'(Entries);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  // Parallel tag compare; keys are unique among valid cells so at most one hits.
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < Entries; i++) begin
      if (match[i]) begin
        match_pos = match_pos | IdxW'(i);
      end
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign commit = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (accept) begin
      hit_q <= |match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= operation_i;
      key_q     <= key_i;
      value_q   <= value_i;
      hit_pos_q <= match_pos;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_UPDATE;
      S_UPDATE: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE:   in_ready_o = 1'b1;
      S_UPDATE: in_ready_o = 1'b0;
      default:  in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Row update
  assign do_move   = commit && hit_q;
  assign do_insert = commit && !hit_q && (op_q == OP_SET);
  assign evict     = (count_q >= eff_cap);

  always_comb begin
    head.valid = 1'b1;
    head.key   = key_q;
    head.value = (op_q == OP_SET) ? value_q : cell_entry[hit_pos_q].value;
  end

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_left[i] = '0;
    end else begin : g_rest
      assign cell_left[i] = cell_entry[i-1];
    end

    always_comb begin
      cell_ctrl[i].take_head = (i == 0) && (do_move || do_insert);
      cell_ctrl[i].take_left = (i != 0) &&
                               (do_insert || (do_move && (IdxW'(i) <= hit_pos_q)));
      // the oldest entry shifts one place down on insert and is dropped there
      cell_ctrl[i].clear     = do_insert && evict && (CntW'(i) == count_q);
    end

    lkvc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[i]),
      .head_i      (head),
      .left_i      (cell_left[i]),
      .lookup_key_i(key_i),
      .entry_o     (cell_entry[i]),
      .match_o     (match[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_insert && !evict) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register
  always_comb begin
    out_hit_d     = hit_q;
    out_evicted_d = !hit_q && (op_q == OP_SET) && evict;
    if (op_q == OP_SET) begin
      out_value_d = value_q;
    end else if (hit_q) begin
      out_value_d = cell_entry[hit_pos_q].value;
    end else begin
      out_value_d = MISS_VALUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_hit_q     <= out_hit_d;
      out_value_q   <= out_value_d;
      out_evicted_q <= out_evicted_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_value_q;
  assign evicted_o    = out_evicted_q;

endmodule
